// ===== hdl/sacl_pkg.sv =====
// Shared types, constants and register codes for the cache lookup block.
`default_nettype none

package sacl_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_WAYS    = 8;
  localparam int DEF_MAX_SETS    = 1024;
  localparam int DEF_ADDR_WIDTH  = 32;
  localparam int DEF_STAMP_WIDTH = 32;

  // Fixed field widths.
  localparam int CFG_W      = 4;
  localparam int CNT_W      = 32;
  localparam int OUT_WAY_W  = 3;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // Register indexes, taken from paddr bits above the byte offset.
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd5;
  localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd5;
  localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 4'd1;

  typedef struct packed {
    logic [CFG_W-1:0] offset_bits;
    logic [CFG_W-1:0] index_bits;
    logic [CFG_W-1:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic [CNT_W-1:0]     access_count;
    logic [CNT_W-1:0]     miss_count;
  } result_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_REDUCE,
    BK_WRITE
  } bk_state_t;

endpackage

`default_nettype wire

// ===== hdl/sacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/sacl_fifo.sv =====
// Small register-based FIFO used for the work queue and the result queue.
`default_nettype none

module sacl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sacl_front.sv =====
// Front end: splits a byte address into set index and tag.
`default_nettype none

module sacl_front #(
  parameter int MAX_SETS   = sacl_pkg::DEF_MAX_SETS,
  parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH,
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  wire logic [ADDR_WIDTH-1:0] address,
  input  wire sacl_pkg::cfg_t        cfg,
  output logic      [SET_W-1:0]      set_idx,
  output logic      [ADDR_WIDTH-1:0] tag
);

  // Largest index width whose set count still fits the set store.
  localparam int MAX_IDX = $clog2(MAX_SETS + 1) - 1;

  logic [sacl_pkg::CFG_W-1:0] ib_sat;
  logic [ADDR_WIDTH-1:0]      shifted;

  always_comb begin
    ib_sat  = (int'(cfg.index_bits) > MAX_IDX) ? sacl_pkg::CFG_W'(MAX_IDX) : cfg.index_bits;
    shifted = address >> cfg.offset_bits;
    set_idx = SET_W'(shifted) & ~({SET_W{1'b1}} << ib_sat);
    tag     = shifted >> ib_sat;
  end

endmodule

`default_nettype wire

// ===== hdl/sacl_back.sv =====
// Back end: set read, tag compare, LRU victim search, write-back and counters.
`default_nettype none

module sacl_back #(
  parameter int MAX_WAYS    = sacl_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS    = sacl_pkg::DEF_MAX_SETS,
  parameter int ADDR_WIDTH  = sacl_pkg::DEF_ADDR_WIDTH,
  parameter int STAMP_WIDTH = sacl_pkg::DEF_STAMP_WIDTH,
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sacl_pkg::cfg_t        cfg,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  input  wire logic [SET_W-1:0]      q_set,
  input  wire logic [ADDR_WIDTH-1:0] q_tag,
  input  wire logic                  res_full,
  output logic                       res_push,
  output sacl_pkg::result_t          res_data,
  output logic                       clearing
);

  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int PW      = 1 << WAY_W;
  localparam int LVL_W   = $clog2(WAY_W + 1);
  localparam int ENTRY_W = 1 + ADDR_WIDTH + STAMP_WIDTH;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;
  localparam int EXT_W   = PW * ENTRY_W;
  localparam int WE_W    = sacl_pkg::CFG_W + 1;
  localparam int CNT_W   = sacl_pkg::CNT_W;

  sacl_pkg::bk_state_t state_r, state_nxt;

  logic [SET_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [SET_W-1:0]       set_r, set_nxt;
  logic [ADDR_WIDTH-1:0]  tag_r, tag_nxt;
  logic [CNT_W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]       miss_r, miss_nxt;
  logic                   hit_r, hit_nxt;
  logic                   free_r, free_nxt;
  logic [WAY_W-1:0]       hit_way_r, hit_way_nxt;
  logic [WAY_W-1:0]       free_way_r, free_way_nxt;
  logic [LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [STAMP_WIDTH-1:0] cand_stamp_r [PW];
  logic [STAMP_WIDTH-1:0] cand_stamp_nxt [PW];
  logic                   cand_use_r [PW];
  logic                   cand_use_nxt [PW];
  logic [WAY_W-1:0]       cand_way_r [PW];
  logic [WAY_W-1:0]       cand_way_nxt [PW];

  logic                   ram_we, ram_re;
  logic [SET_W-1:0]       ram_waddr;
  logic [ROW_W-1:0]       ram_wdata, rd_row;
  logic [EXT_W-1:0]       rd_ext, wr_ext;

  logic                   rd_valid [PW];
  logic [ADDR_WIDTH-1:0]  rd_tag [PW];
  logic [STAMP_WIDTH-1:0] rd_stamp [PW];
  logic                   in_use [PW];
  logic [WE_W-1:0]        ways_eff;
  logic                   hit_any, free_any;
  logic [WAY_W-1:0]       hit_way_c, free_way_c;
  logic                   start;
  logic [STAMP_WIDTH-1:0] stamp_c;
  logic [WAY_W-1:0]       chosen;
  logic [WAY_W+2:0]       chosen_ext;

  sacl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SETS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(q_set),
    .rdata(rd_row)
  );

  assign start    = (state_r == sacl_pkg::BK_IDLE) && !q_empty && !res_full;
  assign clearing = (state_r == sacl_pkg::BK_CLEAR);

  // Effective associativity: zero acts as one, values above the maximum clip.
  always_comb begin
    ways_eff = {1'b0, cfg.ways_in_use};
    if (ways_eff == '0) begin
      ways_eff = WE_W'(1);
    end else if (ways_eff > WE_W'(MAX_WAYS)) begin
      ways_eff = WE_W'(MAX_WAYS);
    end
  end

  // Unpack the set row, padded to a power-of-two way count.
  always_comb begin
    rd_ext = EXT_W'(rd_row);
    for (int i = 0; i < PW; i++) begin
      rd_valid[i] = rd_ext[i*ENTRY_W + ENTRY_W - 1];
      rd_tag[i]   = rd_ext[i*ENTRY_W + STAMP_WIDTH +: ADDR_WIDTH];
      rd_stamp[i] = rd_ext[i*ENTRY_W +: STAMP_WIDTH];
      in_use[i]   = (WE_W'(i) < ways_eff);
    end
  end

  // Hit and first-free search; scanning downward leaves the lowest way.
  always_comb begin
    hit_any    = 1'b0;
    free_any   = 1'b0;
    hit_way_c  = '0;
    free_way_c = '0;
    for (int i = PW - 1; i >= 0; i--) begin
      if (in_use[i] && rd_valid[i] && (rd_tag[i] == tag_r)) begin
        hit_any   = 1'b1;
        hit_way_c = WAY_W'(i);
      end
      if (in_use[i] && !rd_valid[i]) begin
        free_any   = 1'b1;
        free_way_c = WAY_W'(i);
      end
    end
  end

  // The stamp is the access count clipped to the stamp width.
  assign stamp_c = (|(acc_r >> STAMP_WIDTH)) ? '1 : STAMP_WIDTH'(acc_r);

  always_comb begin
    if (hit_r) begin
      chosen = hit_way_r;
    end else if (free_r) begin
      chosen = free_way_r;
    end else begin
      chosen = cand_way_r[0];
    end
  end

  assign chosen_ext = (WAY_W + 3)'(chosen);

  // Write-back row: the chosen way becomes valid with the current tag and stamp.
  always_comb begin
    wr_ext = rd_ext;
    for (int i = 0; i < PW; i++) begin
      if (WAY_W'(i) == chosen) begin
        wr_ext[i*ENTRY_W +: ENTRY_W] = {1'b1, tag_r, stamp_c};
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sacl_pkg::BK_CLEAR: begin
        if (clr_cnt_r == SET_W'(MAX_SETS - 1)) begin
          state_nxt = sacl_pkg::BK_IDLE;
        end
      end
      sacl_pkg::BK_IDLE: begin
        if (start) begin
          state_nxt = sacl_pkg::BK_READ;
        end
      end
      sacl_pkg::BK_READ: begin
        state_nxt = (hit_any || free_any) ? sacl_pkg::BK_WRITE : sacl_pkg::BK_REDUCE;
      end
      sacl_pkg::BK_REDUCE: begin
        if (lvl_r == LVL_W'(WAY_W - 1)) begin
          state_nxt = sacl_pkg::BK_WRITE;
        end
      end
      sacl_pkg::BK_WRITE: begin
        state_nxt = sacl_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = sacl_pkg::BK_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = wr_ext[ROW_W-1:0];
    res_push  = 1'b0;
    unique case (state_r)
      sacl_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      sacl_pkg::BK_IDLE: begin
        q_pop  = start;
        ram_re = start;
      end
      sacl_pkg::BK_WRITE: begin
        ram_we   = 1'b1;
        res_push = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_data.hit          = hit_r;
    res_data.way          = chosen_ext[2:0];
    res_data.access_count = acc_r;
    res_data.miss_count   = miss_nxt;
  end

  // Datapath next values.
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    set_nxt        = set_r;
    tag_nxt        = tag_r;
    acc_nxt        = acc_r;
    miss_nxt       = miss_r;
    hit_nxt        = hit_r;
    free_nxt       = free_r;
    hit_way_nxt    = hit_way_r;
    free_way_nxt   = free_way_r;
    lvl_nxt        = lvl_r;
    cand_stamp_nxt = cand_stamp_r;
    cand_use_nxt   = cand_use_r;
    cand_way_nxt   = cand_way_r;
    case (state_r)
      sacl_pkg::BK_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      sacl_pkg::BK_IDLE: begin
        if (start) begin
          set_nxt = q_set;
          tag_nxt = q_tag;
          acc_nxt = (acc_r == '1) ? acc_r : acc_r + 1'b1;
        end
      end
      sacl_pkg::BK_READ: begin
        hit_nxt      = hit_any;
        free_nxt     = free_any;
        hit_way_nxt  = hit_way_c;
        free_way_nxt = free_way_c;
        lvl_nxt      = '0;
        for (int i = 0; i < PW; i++) begin
          cand_stamp_nxt[i] = rd_stamp[i];
          cand_use_nxt[i]   = in_use[i];
          cand_way_nxt[i]   = WAY_W'(i);
        end
      end
      sacl_pkg::BK_REDUCE: begin
        // One tree level per cycle; the left entry wins ties, keeping the lowest way.
        lvl_nxt = lvl_r + 1'b1;
        for (int i = 0; i < PW / 2; i++) begin
          if (cand_use_r[2*i+1] &&
              (!cand_use_r[2*i] || (cand_stamp_r[2*i+1] < cand_stamp_r[2*i]))) begin
            cand_stamp_nxt[i] = cand_stamp_r[2*i+1];
            cand_use_nxt[i]   = cand_use_r[2*i+1];
            cand_way_nxt[i]   = cand_way_r[2*i+1];
          end else begin
            cand_stamp_nxt[i] = cand_stamp_r[2*i];
            cand_use_nxt[i]   = cand_use_r[2*i];
            cand_way_nxt[i]   = cand_way_r[2*i];
          end
        end
      end
      sacl_pkg::BK_WRITE: begin
        if (!hit_r && (miss_r != '1)) begin
          miss_nxt = miss_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sacl_pkg::BK_CLEAR;
      clr_cnt_r <= '0;
      acc_r     <= '0;
      miss_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      acc_r     <= acc_nxt;
      miss_r    <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    set_r        <= set_nxt;
    tag_r        <= tag_nxt;
    hit_r        <= hit_nxt;
    free_r       <= free_nxt;
    hit_way_r    <= hit_way_nxt;
    free_way_r   <= free_way_nxt;
    lvl_r        <= lvl_nxt;
    cand_stamp_r <= cand_stamp_nxt;
    cand_use_r   <= cand_use_nxt;
    cand_way_r   <= cand_way_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/set_assoc_cache_lru_lookup.sv =====
// Top level of the set-associative cache lookup with LRU replacement.
//
// Each beat pushed on the input queue carries one byte address. The address is
// shifted right by offset_bits, its low index_bits (clipped to what MAX_SETS
// holds) select a set, and the bits above form the tag. The tag is compared
// against the valid ways in use of that set; a hit refreshes the way's age
// stamp, a miss fills the lowest invalid way or else the way with the oldest
// stamp, ties going to the lowest way. Each input beat yields one result beat
// with hit, the way used, and the saturating access and miss counts, popped
// in order from the result queue. A two-entry queue separates the address
// splitter from the lookup engine, and a two-entry result queue lets new
// addresses be taken while results wait. Each set lives in one row of a
// synchronous RAM holding valid, tag and stamp for every way. A lookup steps
// through row read, compare and write-back on a hit or on a miss that finds a
// free way; a miss that evicts adds an oldest-stamp search between compare and
// write-back, which walks a comparison tree one level per cycle. After reset
// the engine clears the valid bits with a pass over all MAX_SETS rows, one row
// per cycle, during which full stays high; configuration writes are
// taken at any time. Registers sit on the APB port at byte addresses 0
// (offset_bits), 4 (index_bits) and 8 (ways_in_use), four bits each; change
// them only while the block is idle. Stored lines survive configuration changes.
`default_nettype none

module set_assoc_cache_lru_lookup #(
  parameter int MAX_WAYS    = sacl_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS    = sacl_pkg::DEF_MAX_SETS,
  parameter int ADDR_WIDTH  = sacl_pkg::DEF_ADDR_WIDTH,
  parameter int STAMP_WIDTH = sacl_pkg::DEF_STAMP_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input queue side.
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [ADDR_WIDTH-1:0]               in_address,
  // Result queue side.
  output logic                                     empty,
  input  wire logic                                pop,
  output logic                                     out_hit,
  output logic      [sacl_pkg::OUT_WAY_W-1:0]      out_way,
  output logic      [sacl_pkg::CNT_W-1:0]          out_access_count,
  output logic      [sacl_pkg::CNT_W-1:0]          out_miss_count,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [sacl_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [sacl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [sacl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int QITEM_W = ADDR_WIDTH + SET_W;
  localparam int RES_W   = $bits(sacl_pkg::result_t);
  localparam int CFG_W   = sacl_pkg::CFG_W;

  sacl_pkg::cfg_t    cfg_r, cfg_nxt;
  sacl_pkg::result_t res_in, res_out;

  logic [sacl_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;
  logic [SET_W-1:0]               f_set;
  logic [ADDR_WIDTH-1:0]          f_tag;
  logic                           q_full, q_empty, q_pop;
  logic [QITEM_W-1:0]             q_rdata;
  logic                           res_full, res_push;
  logic                           clearing;
  logic [RES_W-1:0]               res_rdata;

  // Configuration registers. pready is tied high, so no access gets wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[sacl_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        sacl_pkg::REG_OFFSET_BITS: cfg_nxt.offset_bits = pwdata[CFG_W-1:0];
        sacl_pkg::REG_INDEX_BITS:  cfg_nxt.index_bits  = pwdata[CFG_W-1:0];
        sacl_pkg::REG_WAYS_IN_USE: cfg_nxt.ways_in_use = pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sacl_pkg::REG_OFFSET_BITS: prdata = sacl_pkg::APB_DATA_W'(cfg_r.offset_bits);
      sacl_pkg::REG_INDEX_BITS:  prdata = sacl_pkg::APB_DATA_W'(cfg_r.index_bits);
      sacl_pkg::REG_WAYS_IN_USE: prdata = sacl_pkg::APB_DATA_W'(cfg_r.ways_in_use);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits <= sacl_pkg::RST_OFFSET_BITS;
      cfg_r.index_bits  <= sacl_pkg::RST_INDEX_BITS;
      cfg_r.ways_in_use <= sacl_pkg::RST_WAYS_IN_USE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: address split, then into the work queue.
  sacl_front #(
    .MAX_SETS  (MAX_SETS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_front (
    .address(in_address),
    .cfg    (cfg_r),
    .set_idx(f_set),
    .tag    (f_tag)
  );

  // The input stays blocked while the valid bits are being cleared.
  assign full = q_full || clearing;

  sacl_fifo #(
    .WIDTH(QITEM_W),
    .DEPTH(2)
  ) u_work_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push && !full),
    .wdata({f_tag, f_set}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // Back end: lookup, replacement and counters.
  sacl_back #(
    .MAX_WAYS   (MAX_WAYS),
    .MAX_SETS   (MAX_SETS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .STAMP_WIDTH(STAMP_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_set   (q_rdata[SET_W-1:0]),
    .q_tag   (q_rdata[SET_W +: ADDR_WIDTH]),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_in),
    .clearing(clearing)
  );

  sacl_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_rdata),
    .empty(empty)
  );

  assign res_out          = res_rdata;
  assign out_hit          = res_out.hit;
  assign out_way          = res_out.way;
  assign out_access_count = res_out.access_count;
  assign out_miss_count   = res_out.miss_count;

endmodule

`default_nettype wire
